>>> rtl/core/pstc_pkg.sv
// Package for the polar scan converter: register map, config bundle,
// CORDIC constants. Used by the front end, back end and top level; depends on nothing.
package pstc_pkg;

	localparam int CFG_W   = 16;  // width of every config register
	localparam int WIDE_W  = 24;  // widest range or angle the design supports
	localparam int CORDIC_STAGES = 24;
	localparam int TRIG_W  = 33;  // signed working width: x, y in Q30, z in 2^-32 turn

	localparam logic signed [TRIG_W-1:0] KINV_Q30 = 33'sd652032875;
	localparam logic signed [TRIG_W-1:0] QUARTER_SHIFT = 33'sd536870912;  // 1/8 turn
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic signed [TRIG_W-1:0] ATAN_TURN32 [CORDIC_STAGES] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
		33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
		33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
		33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
		33'sd652,       33'sd326,       33'sd163,       33'sd81
	};

	// register word index (byte address / 4)
	localparam logic [1:0] REG_START_ANGLE = 2'd0;
	localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
	localparam logic [1:0] REG_MIN_RANGE   = 2'd2;
	localparam logic [1:0] REG_MAX_RANGE   = 2'd3;

	localparam logic [CFG_W-1:0] MAX_RANGE_RST = 16'hFFFF;

	typedef struct packed {
		logic [CFG_W-1:0] start_angle;
		logic [CFG_W-1:0] angle_step;
		logic [CFG_W-1:0] min_range;
		logic [CFG_W-1:0] max_range;
	} cfg_t;

endpackage

>>> rtl/core/pstc_queue.sv
// Small register-based FIFO with full/empty flags.
// Used between front and back and on the result side; needs no package items.
module pstc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/core/pstc_front.sv
// Front end: tracks the running beam angle and filters samples by range.
// Depends on pstc_pkg (cfg_t, widths).
module pstc_front #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pstc_pkg::cfg_t        cfg,
	input  logic                  accept,
	input  logic [RANGE_BITS-1:0] range_mm,
	input  logic                  range_valid,
	input  logic                  scan_start,
	output logic                  wr,
	output logic [RANGE_BITS-1:0] wr_range,
	output logic [ANGLE_BITS-1:0] wr_angle
);
	logic [ANGLE_BITS-1:0]        beam_angle_q;
	logic [ANGLE_BITS-1:0]        angle_use;
	logic [pstc_pkg::WIDE_W-1:0]  start_wide, step_wide, r_wide, min_wide, max_wide;
	logic                         in_window;

	assign start_wide = pstc_pkg::WIDE_W'(cfg.start_angle);
	assign step_wide  = pstc_pkg::WIDE_W'(cfg.angle_step);
	assign r_wide     = pstc_pkg::WIDE_W'(range_mm);
	assign min_wide   = pstc_pkg::WIDE_W'(cfg.min_range);
	assign max_wide   = pstc_pkg::WIDE_W'(cfg.max_range);

	// reload happens before this sample takes its angle
	assign angle_use = scan_start ? start_wide[ANGLE_BITS-1:0] : beam_angle_q;
	assign in_window = (r_wide > min_wide) && (r_wide < max_wide);

	assign wr       = accept && range_valid && in_window;
	assign wr_range = range_mm;
	assign wr_angle = angle_use;

	// advance after every sample, kept or dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q <= '0;
		end else if (accept) begin
			beam_angle_q <= angle_use + step_wide[ANGLE_BITS-1:0];
		end
	end

endmodule

>>> rtl/core/pstc_cordic.sv
// Back end: pipelined rotation CORDIC, quadrant fix-up, scale by range,
// round and saturate. Depends on pstc_pkg (CORDIC table and widths).
module pstc_cordic #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_empty,
	input  logic [RANGE_BITS-1:0] in_range,
	input  logic [ANGLE_BITS-1:0] in_angle,
	output logic                  in_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output logic [RANGE_BITS:0]   out_x,
	output logic [RANGE_BITS:0]   out_y
);
	localparam int N  = pstc_pkg::CORDIC_STAGES;
	localparam int TW = pstc_pkg::TRIG_W;
	localparam int PW = RANGE_BITS + 1 + TW;
	localparam int VW = PW - 30;

	logic adv;

	logic                  vld_s [N+1];
	logic signed [TW-1:0]  x_s   [N+1];
	logic signed [TW-1:0]  y_s   [N+1];
	logic signed [TW-1:0]  z_s   [N+1];
	logic [1:0]            q_s   [N+1];
	logic [RANGE_BITS-1:0] r_s   [N+1];

	logic                  vld_s25, vld_s26;
	logic signed [TW-1:0]  c_s25, s_s25;
	logic [RANGE_BITS-1:0] r_s25;
	logic signed [PW-1:0]  px_s26, py_s26;

	logic [31:0]           turn_raw, turn_u;
	logic signed [TW-1:0]  z_init;
	logic signed [VW-1:0]  vx, vy;
	logic signed [PW-1:0]  half_lsb;
	logic signed [VW-1:0]  lim;
	logic signed [VW-1:0]  neg_lim;

	// the whole back end holds while the result queue is full
	assign adv    = !out_full;
	assign in_pop = adv && !in_empty;

	assign turn_raw = 32'(in_angle) << (32 - ANGLE_BITS);
	assign turn_u   = turn_raw + pstc_pkg::EIGHTH_TURN;
	assign z_init   = TW'(signed'({1'b0, turn_u[29:0]})) - pstc_pkg::QUARTER_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= pstc_pkg::KINV_Q30;
			y_s[0] <= '0;
			z_s[0] <= z_init;
			q_s[0] <= turn_u[31:30];
			r_s[0] <= in_range;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_s[i+1] <= q_s[i];
				r_s[i+1] <= r_s[i];
				if (!z_s[i][TW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - pstc_pkg::ATAN_TURN32[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + pstc_pkg::ATAN_TURN32[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s25 <= 1'b0;
			vld_s26 <= 1'b0;
		end else if (adv) begin
			vld_s25 <= vld_s[N];
			vld_s26 <= vld_s25;
		end
	end

	// rotate the residual result back into its quadrant, then scale by range
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s25 <= r_s[N];
			unique case (q_s[N])
				2'd0: begin
					c_s25 <= x_s[N];
					s_s25 <= y_s[N];
				end
				2'd1: begin
					c_s25 <= -y_s[N];
					s_s25 <= x_s[N];
				end
				2'd2: begin
					c_s25 <= -x_s[N];
					s_s25 <= -y_s[N];
				end
				default: begin
					c_s25 <= y_s[N];
					s_s25 <= -x_s[N];
				end
			endcase
			px_s26 <= PW'(signed'({1'b0, r_s25})) * PW'(c_s25);
			py_s26 <= PW'(signed'({1'b0, r_s25})) * PW'(s_s25);
		end
	end

	// round half up, drop 30 fraction bits, clamp to +-(2^RANGE_BITS - 1)
	assign half_lsb = PW'(signed'(33'sd536870912));
	assign lim      = VW'(signed'({1'b0, {RANGE_BITS{1'b1}}}));
	assign neg_lim  = -lim;
	assign vx       = VW'((px_s26 + half_lsb) >>> 30);
	assign vy       = VW'((py_s26 + half_lsb) >>> 30);

	always_comb begin
		out_push = adv && vld_s26;
		priority if (vx > lim) begin
			out_x = lim[RANGE_BITS:0];
		end else if (vx < neg_lim) begin
			out_x = neg_lim[RANGE_BITS:0];
		end else begin
			out_x = vx[RANGE_BITS:0];
		end
		priority if (vy > lim) begin
			out_y = lim[RANGE_BITS:0];
		end else if (vy < neg_lim) begin
			out_y = neg_lim[RANGE_BITS:0];
		end else begin
			out_y = vy[RANGE_BITS:0];
		end
	end

endmodule

>>> rtl/core/polar_scan_to_cartesian.sv
// Top level of the polar scan converter: config registers, front end,
// middle queue, CORDIC back end and result queue.
// Depends on pstc_pkg, pstc_queue, pstc_front, pstc_cordic.
//
//   channel   handshake              words
//   input     push / full            range_mm, range_valid, scan_start
//   result    pop / empty            x_mm, y_mm
//   config    psel/penable/pwrite    paddr, pwdata -> prdata, pready
//
// One sample is taken per cycle while full is low; a kept sample passes
// through the middle queue, the load stage, the 24 CORDIC stages, the
// quadrant and multiply stages and the result queue before it shows up
// on the result ports.
// A full result queue holds the whole back end; the middle queue then fills
// and raises full. Dropped samples only advance the beam angle.
// Reset clears the angle, the queues and the registers (max_range to all ones).
module polar_scan_to_cartesian #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [RANGE_BITS-1:0]      range_mm,
	input  logic                       range_valid,
	input  logic                       scan_start,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [RANGE_BITS:0] x_mm,
	output logic signed [RANGE_BITS:0] y_mm,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	localparam int MQ_W = RANGE_BITS + ANGLE_BITS;
	localparam int OQ_W = 2 * (RANGE_BITS + 1);

	pstc_pkg::cfg_t cfg_q;

	logic                  accept, fe_wr, mq_full, mq_empty, mq_pop;
	logic [RANGE_BITS-1:0] fe_range, mq_range;
	logic [ANGLE_BITS-1:0] fe_angle, mq_angle;
	logic                  oq_full, be_push;
	logic [RANGE_BITS:0]   be_x, be_y;
	logic [OQ_W-1:0]       oq_rdata;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle <= '0;
			cfg_q.angle_step  <= '0;
			cfg_q.min_range   <= '0;
			cfg_q.max_range   <= pstc_pkg::MAX_RANGE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pstc_pkg::REG_START_ANGLE: cfg_q.start_angle <= pwdata[15:0];
				pstc_pkg::REG_ANGLE_STEP:  cfg_q.angle_step  <= pwdata[15:0];
				pstc_pkg::REG_MIN_RANGE:   cfg_q.min_range   <= pwdata[15:0];
				default:                   cfg_q.max_range   <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pstc_pkg::REG_START_ANGLE: prdata = 32'(cfg_q.start_angle);
			pstc_pkg::REG_ANGLE_STEP:  prdata = 32'(cfg_q.angle_step);
			pstc_pkg::REG_MIN_RANGE:   prdata = 32'(cfg_q.min_range);
			default:                   prdata = 32'(cfg_q.max_range);
		endcase
	end

	assign full   = mq_full;
	assign accept = push && !mq_full;

	pstc_front #(
		.RANGE_BITS(RANGE_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.range_mm   (range_mm),
		.range_valid(range_valid),
		.scan_start (scan_start),
		.wr         (fe_wr),
		.wr_range   (fe_range),
		.wr_angle   (fe_angle)
	);

	pstc_queue #(
		.WIDTH(MQ_W),
		.DEPTH(4)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_wr),
		.wdata ({fe_range, fe_angle}),
		.full  (mq_full),
		.pop   (mq_pop),
		.rdata ({mq_range, mq_angle}),
		.empty (mq_empty)
	);

	pstc_cordic #(
		.RANGE_BITS(RANGE_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_empty(mq_empty),
		.in_range(mq_range),
		.in_angle(mq_angle),
		.in_pop  (mq_pop),
		.out_full(oq_full),
		.out_push(be_push),
		.out_x   (be_x),
		.out_y   (be_y)
	);

	pstc_queue #(
		.WIDTH(OQ_W),
		.DEPTH(2)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (be_push),
		.wdata ({be_x, be_y}),
		.full  (oq_full),
		.pop   (pop),
		.rdata (oq_rdata),
		.empty (empty)
	);

	assign x_mm = oq_rdata[OQ_W-1:RANGE_BITS+1];
	assign y_mm = oq_rdata[RANGE_BITS:0];

endmodule
